// ===== rtl/core/sorted_timer_callout_queue_assert.svh =====
// Assertion helpers shared by the queue RTL.
`ifndef SORTED_TIMER_CALLOUT_QUEUE_ASSERT_SVH
`define SORTED_TIMER_CALLOUT_QUEUE_ASSERT_SVH

// Same-cycle implication.
`define STCQ_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define STCQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/stcq_pkg.sv =====
package stcq_pkg;

   localparam int unsigned DataW      = 32;
   localparam int unsigned MaxResults = 16;
   localparam int unsigned ResCntW    = $clog2(MaxResults);

   typedef enum logic [1:0] {
      CMD_ADD    = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_TICK   = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      KIND_ADDED    = 3'd0,
      KIND_FULL     = 3'd1,
      KIND_REMOVED  = 3'd2,
      KIND_NOTFOUND = 3'd3,
      KIND_EXPIRED  = 3'd4,
      KIND_IDLE     = 3'd5
   } kind_type;

   typedef struct packed {
      logic [DataW-1:0] deadline;
      logic [DataW-1:0] func;
      logic [DataW-1:0] arg;
      logic [DataW-1:0] ident;
   } entry_type;

   typedef struct packed {
      logic             insert;
      logic             drop;
      logic [DataW-1:0] target;
   } cell_ctl_type;

   typedef struct packed {
      logic valid;
      logic later;   // holds a deadline after the one being inserted
      logic match;   // ident equals the remove target
   } cell_status_type;

endpackage

// ===== rtl/core/stcq_cell.sv =====
module stcq_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  stcq_pkg::cell_ctl_type   ctl,
   input  stcq_pkg::entry_type      new_entry,
   input  stcq_pkg::entry_type      left_entry,
   input  logic                     left_valid,
   input  logic                     left_later,
   input  stcq_pkg::entry_type      right_entry,
   input  logic                     right_valid,
   input  logic                     drop_here,
   output stcq_pkg::entry_type      entry,
   output stcq_pkg::cell_status_type status
);

   stcq_pkg::entry_type entry_ff, entry_in;
   logic                valid_ff, valid_in;
   logic                later;

   assign later = valid_ff && (entry_ff.deadline > new_entry.deadline);

   // Sorted insert: the later suffix shifts right by one, the first
   // later (or first empty) cell takes the new entry.
   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      if (ctl.insert) begin
         if (valid_ff ? later : left_valid) begin
            entry_in = left_later ? left_entry : new_entry;
            valid_in = 1'b1;
         end
      end else if (ctl.drop && drop_here) begin
         entry_in = right_entry;
         valid_in = right_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry        = entry_ff;
   assign status.valid = valid_ff;
   assign status.later = later;
   assign status.match = valid_ff && (entry_ff.ident == ctl.target);

endmodule

// ===== rtl/core/sorted_timer_callout_queue.sv =====
// Timer callout queue holding up to DEPTH entries sorted by deadline in a
// row of cells; equal deadlines keep arrival order. One request is handled
// at a time: an add is placed by all cells comparing and shifting at once,
// a remove registers the id match and then scans it one cell per cycle,
// and a tick emits expired entries from the head one at a time, at most 16
// per tick, since each emitted head shifts the row left; a tick with
// nothing expired gives a single idle response. A held response that waits
// on rsp_tready holds back the next tick or result. A new request is taken
// while the last response still waits.
// Deadline comparisons are unsigned 32-bit, with no wrap handling.
`include "sorted_timer_callout_queue_assert.svh"

module sorted_timer_callout_queue #(
   parameter int unsigned DEPTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [1:0]   req_tuser,   // command
   input  logic [127:0] req_tdata,   // delay_ms, func_handle, arg_handle, target_id
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [2:0]   rsp_tuser,   // kind
   output logic [95:0]  rsp_tdata,   // entry_id, expired_func, expired_arg
   output logic         rsp_tlast
);

   localparam int unsigned IdxW = $clog2(DEPTH);
   localparam int unsigned DW   = stcq_pkg::DataW;
   localparam logic [DEPTH-1:0] OneVec = DEPTH'(1);

   typedef enum logic [4:0] {
      S_IDLE     = 5'b00001,
      S_DISPATCH = 5'b00010,
      S_SCAN     = 5'b00100,
      S_EMIT     = 5'b01000,
      S_RESULT   = 5'b10000
   } state_type;

   state_type                         state_ff, state_in;
   logic [1:0]                        cmd_ff, cmd_in;
   logic [DW-1:0]                     deadline_ff, deadline_in;
   logic [DW-1:0]                     func_ff, func_in;
   logic [DW-1:0]                     arg_ff, arg_in;
   logic [DW-1:0]                     target_ff, target_in;
   logic [DW-1:0]                     now_ff, now_in;
   logic [DW-1:0]                     last_id_ff, last_id_in;
   logic [DEPTH-1:0]                  match_ff, match_in;
   logic [IdxW-1:0]                   scan_ff, scan_in;
   logic [stcq_pkg::ResCntW-1:0]      emit_cnt_ff, emit_cnt_in;
   stcq_pkg::kind_type                res_kind_ff, res_kind_in;
   logic [DW-1:0]                     res_id_ff, res_id_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   stcq_pkg::kind_type                rsp_kind_ff, rsp_kind_in;
   logic [DW-1:0]                     rsp_id_ff, rsp_id_in;
   logic [DW-1:0]                     rsp_func_ff, rsp_func_in;
   logic [DW-1:0]                     rsp_arg_ff, rsp_arg_in;
   logic                              rsp_last_ff, rsp_last_in;

   stcq_pkg::cell_ctl_type            ctl;
   stcq_pkg::entry_type               new_entry;
   stcq_pkg::entry_type               cell_entry [DEPTH];
   stcq_pkg::cell_status_type         cell_stat  [DEPTH];
   logic [DEPTH-1:0]                  valid_vec;
   logic [DEPTH-1:0]                  match_vec;
   logic [IdxW-1:0]                   drop_pos;
   logic                              out_free;
   logic                              head_expired;
   logic                              emit_last;

   assign new_entry.deadline = deadline_ff;
   assign new_entry.func     = func_ff;
   assign new_entry.arg      = arg_ff;
   assign new_entry.ident    = last_id_ff + DW'(1);

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      stcq_pkg::entry_type left_e, right_e;
      logic                left_v, left_l, right_v, drop_here;

      if (i == 0) begin : g_head
         assign left_e = new_entry;
         assign left_v = 1'b1;
         assign left_l = 1'b0;
      end else begin : g_body
         assign left_e = cell_entry[i-1];
         assign left_v = cell_stat[i-1].valid;
         assign left_l = cell_stat[i-1].later;
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_e = cell_entry[i];
         assign right_v = 1'b0;
      end else begin : g_inner
         assign right_e = cell_entry[i+1];
         assign right_v = cell_stat[i+1].valid;
      end

      assign drop_here    = (IdxW'(i) >= drop_pos);
      assign valid_vec[i] = cell_stat[i].valid;
      assign match_vec[i] = cell_stat[i].match;

      stcq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .new_entry   (new_entry),
         .left_entry  (left_e),
         .left_valid  (left_v),
         .left_later  (left_l),
         .right_entry (right_e),
         .right_valid (right_v),
         .drop_here   (drop_here),
         .entry       (cell_entry[i]),
         .status      (cell_stat[i])
      );
   end

   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign head_expired = cell_stat[0].valid && (cell_entry[0].deadline <= now_ff);
   // last of the run if the cap is reached or the next head is still pending
   assign emit_last    = (emit_cnt_ff == stcq_pkg::ResCntW'(stcq_pkg::MaxResults - 1)) ||
                         !(cell_stat[1].valid && (cell_entry[1].deadline <= now_ff));

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      deadline_in = deadline_ff;
      func_in     = func_ff;
      arg_in      = arg_ff;
      target_in   = target_ff;
      now_in      = now_ff;
      last_id_in  = last_id_ff;
      match_in    = match_ff;
      scan_in     = scan_ff;
      emit_cnt_in = emit_cnt_ff;
      res_kind_in = res_kind_ff;
      res_id_in   = res_id_ff;
      ctl.insert  = 1'b0;
      ctl.drop    = 1'b0;
      ctl.target  = target_ff;
      drop_pos    = '0;

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_func_in  = rsp_func_ff;
      rsp_arg_in   = rsp_arg_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd_in      = req_tuser;
               deadline_in = now_ff + req_tdata[31:0];
               func_in     = req_tdata[63:32];
               arg_in      = req_tdata[95:64];
               target_in   = req_tdata[127:96];
               if (req_tuser == stcq_pkg::CMD_TICK) begin
                  now_in = now_ff + DW'(1);
               end
               scan_in     = '0;
               emit_cnt_in = '0;
               state_in    = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            match_in = match_vec;
            unique case (cmd_ff)
               stcq_pkg::CMD_ADD: begin
                  if (valid_vec[DEPTH-1]) begin
                     res_kind_in = stcq_pkg::KIND_FULL;
                     res_id_in   = '0;
                  end else begin
                     ctl.insert  = 1'b1;
                     last_id_in  = new_entry.ident;
                     res_kind_in = stcq_pkg::KIND_ADDED;
                     res_id_in   = new_entry.ident;
                  end
                  state_in = S_RESULT;
               end
               stcq_pkg::CMD_REMOVE: begin
                  state_in = S_SCAN;
               end
               stcq_pkg::CMD_TICK: begin
                  state_in = S_EMIT;
               end
               default: begin
                  res_kind_in = stcq_pkg::KIND_IDLE;
                  res_id_in   = '0;
                  state_in    = S_RESULT;
               end
            endcase
         end
         S_SCAN: begin
            priority if (match_ff[scan_ff]) begin
               ctl.drop    = 1'b1;
               drop_pos    = scan_ff;
               res_kind_in = stcq_pkg::KIND_REMOVED;
               res_id_in   = target_ff;
               state_in    = S_RESULT;
            end else if (scan_ff == IdxW'(DEPTH - 1)) begin
               res_kind_in = stcq_pkg::KIND_NOTFOUND;
               res_id_in   = '0;
               state_in    = S_RESULT;
            end else begin
               scan_in = scan_ff + IdxW'(1);
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (head_expired) begin
                  rsp_kind_in = stcq_pkg::KIND_EXPIRED;
                  rsp_id_in   = cell_entry[0].ident;
                  rsp_func_in = cell_entry[0].func;
                  rsp_arg_in  = cell_entry[0].arg;
                  rsp_last_in = emit_last;
                  ctl.drop    = 1'b1;
                  emit_cnt_in = emit_cnt_ff + stcq_pkg::ResCntW'(1);
                  if (emit_last) begin
                     state_in = S_IDLE;
                  end
               end else begin
                  rsp_kind_in = stcq_pkg::KIND_IDLE;
                  rsp_id_in   = '0;
                  rsp_func_in = '0;
                  rsp_arg_in  = '0;
                  rsp_last_in = 1'b1;
                  state_in    = S_IDLE;
               end
            end
         end
         S_RESULT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = res_kind_ff;
               rsp_id_in    = res_id_ff;
               rsp_func_in  = '0;
               rsp_arg_in   = '0;
               rsp_last_in  = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         now_ff       <= '0;
         last_id_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         now_ff       <= now_in;
         last_id_ff   <= last_id_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      deadline_ff <= deadline_in;
      func_ff     <= func_in;
      arg_ff      <= arg_in;
      target_ff   <= target_in;
      match_ff    <= match_in;
      scan_ff     <= scan_in;
      emit_cnt_ff <= emit_cnt_in;
      res_kind_ff <= res_kind_in;
      res_id_ff   <= res_id_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_func_ff <= rsp_func_in;
      rsp_arg_ff  <= rsp_arg_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {rsp_arg_ff, rsp_func_ff, rsp_id_ff};
   assign rsp_tlast  = rsp_last_ff;

   // occupied cells always form a prefix of the row
   `STCQ_ASSERT_IMPLY(a_valid_prefix, clock, reset, 1'b1, (valid_vec & (valid_vec + OneVec)) == '0, "occupied cells not contiguous from head")
   `STCQ_ASSERT_IMPLY(a_head_sorted, clock, reset, cell_stat[1].valid, cell_entry[0].deadline <= cell_entry[1].deadline, "head pair out of deadline order")
   `STCQ_ASSERT_NEXT(a_full_add_holds, clock, reset, (state_ff == S_DISPATCH) && (cmd_ff == stcq_pkg::CMD_ADD) && valid_vec[DEPTH-1], $stable(valid_vec) && $stable(last_id_ff), "add to full table changed state")

endmodule
